>>> src/vpv_pkg.sv
package vpv_pkg;

  // image and table geometry
  localparam int IMG_WIDTH  = 256;
  localparam int IMG_HEIGHT = 256;
  localparam int MAX_LINES  = 4096;
  localparam int CELLS      = IMG_WIDTH * IMG_HEIGHT;

  localparam int LINE_AW  = $clog2(MAX_LINES);
  localparam int LCNT_W   = $clog2(MAX_LINES + 1);
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int COL_W    = $clog2(IMG_WIDTH);
  localparam int ROW_W    = $clog2(IMG_HEIGHT);
  localparam int DIV_BITS = (COL_W > ROW_W) ? COL_W : ROW_W;

  // field widths
  localparam int ANG_W   = 16;
  localparam int RHO_W   = 16;
  localparam int VOTE_W  = 16;
  localparam int THR_W   = 16;
  localparam int IDX_W   = 12;
  localparam int PADDR_W = 3;

  // arithmetic widths
  localparam int OPND_W = 17;
  localparam int TRIG_W = 17;
  localparam int ACC_W  = 36;
  localparam int NUM_W  = 48;
  localparam int CRD_W  = 34;
  localparam int ZW     = 33;

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [29:0] CORDIC_KINV = 30'd652032874;

  localparam logic signed [15:0] BAND_STEPS   = 16'sd2086;
  localparam logic signed [15:0] FOLD_GAP     = 16'sd3650;
  localparam logic signed [ACC_W-1:0] PAR_LIM = ACC_W'(11);
  localparam logic [THR_W-1:0] THR_RESET      = 16'd30;

  localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef enum logic [1:0] {
    OP_NEW_FRAME = 2'd0,
    OP_EDGE      = 2'd1,
    OP_VOTE      = 2'd2,
    OP_REPORT    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'd0
  } reg_e;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_req_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } mac_op_t;

  // angle inside the excluded bands around 0, +pi/2 and +-pi
  function automatic logic in_band(logic signed [ANG_W-1:0] a);
    logic signed [ANG_W+1:0] d;
    d = $signed({{2{a[ANG_W-1]}}, a}) - 18'sd16384;
    return (a >= -BAND_STEPS && a <= BAND_STEPS) ||
           (d >= -18'(BAND_STEPS) && d <= 18'(BAND_STEPS)) ||
           (a >= 16'sd30682) || (a <= -16'sd30682);
  endfunction

endpackage

>>> src/vpv_if.sv
interface vpv_in_if import vpv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic signed [15:0]      grad_x;
  logic signed [15:0]      grad_y;
  logic [7:0]              pixel_row;
  logic [7:0]              pixel_col;
  logic [IDX_W-1:0]        first_line;
  logic [IDX_W-1:0]        second_line;

  modport source (output valid, operation, grad_x, grad_y, pixel_row, pixel_col,
                  first_line, second_line, input ready);
  modport sink (input valid, operation, grad_x, grad_y, pixel_row, pixel_col,
                first_line, second_line, output ready);
endinterface

interface vpv_out_if import vpv_pkg::*;;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              table_full;
  logic [LCNT_W-1:0] lines_stored;
  logic [7:0]        peak_col;
  logic [7:0]        peak_row;
  logic [VOTE_W-1:0] peak_votes;

  modport source (output valid, accepted, table_full, lines_stored, peak_col, peak_row,
                  peak_votes, input ready);
  modport sink (input valid, accepted, table_full, lines_stored, peak_col, peak_row,
                peak_votes, output ready);
endinterface

>>> src/vpv_ram.sv
module vpv_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/vpv_cordic.sv
module vpv_cordic import vpv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cordic_req_t              req_i,
  input  logic signed [15:0]       gx_i,
  input  logic signed [15:0]       gy_i,
  input  logic signed [ANG_W-1:0]  ang_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [ANG_W-1:0]  angle_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [CRD_W-1:0] x_q, x_d, y_q, y_d, xs, ys, gx_s, gy_s, rx, ry;
  logic signed [ZW-1:0]    z_q, z_d, arc, z0;
  logic [STEP_W-1:0]       it_q, it_d;
  logic                    run_q, run_d, done_q, done_d;
  logic                    vec_q, vec_d, zero_q, zero_d, flip_q, flip_d, up;
  logic [31:0]             zsum;

  always_comb begin
    xs   = x_q >>> it_q;
    ys   = y_q >>> it_q;
    arc  = $signed(ZW'(ARC_TABLE[it_q]));
    up   = vec_q ? y_q[CRD_W-1] : !z_q[ZW-1];
    gx_s = CRD_W'(gx_i) <<< 14;
    gy_s = CRD_W'(gy_i) <<< 14;
    z0   = $signed({ang_i[ANG_W-1], ang_i, 16'b0});

    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q;
    run_d = run_q; done_d = 1'b0;
    vec_d = vec_q; zero_d = zero_q; flip_d = flip_q;

    if (req_i.start) begin
      run_d = 1'b1;
      it_d  = '0;
      vec_d = req_i.vectoring;
      flip_d = 1'b0;
      if (req_i.vectoring) begin
        zero_d = (gx_i == 16'sd0) && (gy_i == 16'sd0);
        if (gx_i[15]) begin
          x_d = -gx_s; y_d = -gy_s; z_d = ZW'(33'h080000000);
        end else begin
          x_d = gx_s; y_d = gy_s; z_d = '0;
        end
      end else begin
        zero_d = 1'b0;
        x_d = CRD_W'(CORDIC_KINV);
        y_d = '0;
        priority if (z0 > 33'sd1073741824) begin
          z_d = z0 - 33'sd2147483648; flip_d = 1'b1;
        end else if (z0 < -33'sd1073741824) begin
          z_d = z0 + 33'sd2147483648; flip_d = 1'b1;
        end else begin
          z_d = z0;
        end
      end
    end else if (run_q) begin
      if (up) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - arc;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + arc;
      end
      it_d = it_q + 1'b1;
      if (it_q == STEP_W'(CORDIC_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; it_q <= it_d;
    vec_q <= vec_d; zero_q <= zero_d; flip_q <= flip_d;
  end

  // rounding of the results to 16-bit angle steps and Q15
  always_comb begin
    zsum = z_q[31:0] + 32'h8000;
    rx   = (x_q + CRD_W'(16384)) >>> 15;
    ry   = (y_q + CRD_W'(16384)) >>> 15;
    angle_o = zero_q ? '0 : $signed(zsum[31:16]);
    cos_o   = flip_q ? -TRIG_W'(rx) : TRIG_W'(rx);
    sin_o   = flip_q ? -TRIG_W'(ry) : TRIG_W'(ry);
  end

  assign busy_o = run_q;
  assign done_o = done_q;

endmodule

>>> src/vpv_mac.sv
module vpv_mac import vpv_pkg::*; (
  input  logic                     clk_i,
  input  mac_op_t                  op_i,
  input  logic signed [OPND_W-1:0] a_i,
  input  logic signed [OPND_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [2*OPND_W-1:0] prod;
  logic signed [ACC_W-1:0]    term, acc_q, acc_d;

  always_comb begin
    prod  = a_i * b_i;
    term  = op_i.neg ? -ACC_W'(prod) : ACC_W'(prod);
    acc_d = (op_i.clr ? '0 : acc_q) + term;
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> src/vpv_div.sv
module vpv_div import vpv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [NUM_W-1:0]        den_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic [DIV_BITS-1:0]     quo_o
);

  localparam int KW = $clog2(DIV_BITS);

  logic [NUM_W-1:0]    rem_q, rem_d, den_q, den_d, sub;
  logic [DIV_BITS-1:0] quo_q, quo_d;
  logic [KW-1:0]       k_q, k_d;
  logic                run_q, run_d, done_q, done_d, ok_q, ok_d;

  always_comb begin
    rem_d = rem_q; den_d = den_q; quo_d = quo_q; k_d = k_q;
    run_d = run_q; done_d = 1'b0; ok_d = ok_q;
    sub = den_q << k_q;
    if (start_i) begin
      // quotient must land in [0, 2^DIV_BITS)
      ok_d  = !num_i[NUM_W-1] && (NUM_W'(num_i) < (den_i << DIV_BITS));
      rem_d = NUM_W'(num_i);
      den_d = den_i;
      quo_d = '0;
      k_d   = KW'(DIV_BITS - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_q >= sub) begin
        rem_d = rem_q - sub;
        quo_d[k_q] = 1'b1;
      end
      k_d = k_q - 1'b1;
      if (k_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; k_q <= k_d; ok_q <= ok_d;
  end

  assign done_o = done_q;
  assign ok_o   = ok_q;
  assign quo_o  = quo_q;

endmodule

>>> src/vanishing_point_voting.sv
// vanishing point voter
// in_i carries one operation per transfer: new frame, edge pixel, vote pair
// or report peak. out_o returns exactly one result per operation, in order,
// with the line count and the peak after that operation.
// the block works on one item at a time and drops in_i.ready until the
// result is loaded into the output register; the next item is taken while
// that result still waits for out_o.ready, and a stalled receiver only holds
// back the end of the following item.
// the work per item, with the shared 20-step cordic and 8-step divider:
//   report (no computation), edge pixel (atan2 then sin/cos),
//   vote pair (two sin/cos, six products, two divisions),
//   new frame (one vote cell cleared per cycle).
// at reset the same clearing pass runs over all 65536 vote cells and
// in_i.ready stays low; threshold resets to 30, line count and peak to 0.
// apb register 0 at address 0 holds the magnitude threshold; pready is
// always high, writes are expected only while the block is idle.
module vanishing_point_voting import vpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  vpv_in_if.sink             in_i,
  vpv_out_if.source          out_o
);

  typedef enum logic [23:0] {
    S_CLEAR  = 24'h000001,
    S_IDLE   = 24'h000002,
    S_MAG    = 24'h000004,
    S_ATAN   = 24'h000008,
    S_ATANW  = 24'h000010,
    S_SCE    = 24'h000020,
    S_SCEW   = 24'h000040,
    S_RHO    = 24'h000080,
    S_RD1    = 24'h000100,
    S_RD2    = 24'h000200,
    S_RD3    = 24'h000400,
    S_SC1    = 24'h000800,
    S_SC1W   = 24'h001000,
    S_SC2    = 24'h002000,
    S_SC2W   = 24'h004000,
    S_PROD   = 24'h008000,
    S_NUM    = 24'h010000,
    S_DIVX   = 24'h020000,
    S_DIVXW  = 24'h040000,
    S_DIVY   = 24'h080000,
    S_DIVYW  = 24'h100000,
    S_CELLRD = 24'h200000,
    S_CELLWR = 24'h400000,
    S_FINISH = 24'h800000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [2:0]         step_q, step_d;
  logic [CELL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic               clr_reply_q, clr_reply_d;
  logic               res_acc_q, res_acc_d, res_full_q, res_full_d;
  logic [LCNT_W-1:0]  line_total_q, line_total_d;
  logic [VOTE_W-1:0]  best_votes_q, best_votes_d;
  logic [COL_W-1:0]   best_col_q, best_col_d;
  logic [ROW_W-1:0]   best_row_q, best_row_d;
  logic [THR_W-1:0]   thr_q;
  logic               out_valid_q, out_valid_d;

  // item payload and intermediate values
  logic signed [15:0]       gx_q, gx_d, gy_q, gy_d;
  logic [7:0]               row_q, row_d, col_q, col_d;
  logic [IDX_W-1:0]         i1_q, i1_d, i2_q, i2_d;
  logic signed [ANG_W-1:0]  ang_q, ang_d, ang2_q, ang2_d;
  logic signed [RHO_W-1:0]  r1_q, r1_d, r2_q, r2_d;
  logic signed [TRIG_W-1:0] c1_q, c1_d, s1_q, s1_d, c2_q, c2_d, s2_q, s2_d;
  logic signed [ACC_W-1:0]  det_q, det_d, xn_q, xn_d, yn_q, yn_d;
  logic signed [NUM_W-1:0]  numx_q, numx_d, numy_q, numy_d;
  logic [NUM_W-1:0]         den_q, den_d;
  logic [DIV_BITS-1:0]      cx_q, cx_d, cy_q, cy_d;
  logic [CELL_AW-1:0]       cell_q, cell_d;

  // output register
  logic              o_acc_q, o_full_q;
  logic [LCNT_W-1:0] o_lines_q;
  logic [7:0]        o_col_q, o_row_q;
  logic [VOTE_W-1:0] o_votes_q;

  // shared units
  cordic_req_t              cord_req;
  logic                     cord_busy, cord_done;
  logic signed [ANG_W-1:0]  cord_ang_in, cord_angle;
  logic signed [TRIG_W-1:0] cord_cos, cord_sin;
  mac_op_t                  mac_op;
  logic signed [OPND_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     div_start, div_done, div_ok;
  logic [DIV_BITS-1:0]      div_quo;

  // memories
  logic                lram_we;
  logic [LINE_AW-1:0]  lram_addr;
  logic [31:0]         lram_wdata, lram_rdata;
  logic                vram_we;
  logic [CELL_AW-1:0]  vram_addr;
  logic [VOTE_W-1:0]   vram_wdata, vram_rdata, vote_new;

  // scratch
  logic                    in_fire, cfg_wr;
  logic signed [15:0]      fold_gap;
  logic signed [ACC_W-1:0] rho_sum;
  logic signed [NUM_W-1:0] det_w, xn_w, yn_w, nx, ny;
  logic signed [OPND_W-1:0] px, py;

  assign in_fire  = in_i.valid && in_i.ready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {16'b0, thr_q};
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[PADDR_W-1:2] == REG_THRESHOLD) ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // shared units
  vpv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cord_req),
    .gx_i    (gx_q),
    .gy_i    (gy_q),
    .ang_i   (cord_ang_in),
    .busy_o  (cord_busy),
    .done_o  (cord_done),
    .angle_o (cord_angle),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  vpv_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (mac_acc)
  );

  vpv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((state_q == S_DIVY) ? numy_q : numx_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .ok_o    (div_ok),
    .quo_o   (div_quo)
  );

  // line table: angle in the upper half, rho in the lower half
  vpv_ram #(.Width(32), .Depth(MAX_LINES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .addr_i  (lram_addr),
    .wdata_i (lram_wdata),
    .rdata_o (lram_rdata)
  );

  vpv_ram #(.Width(VOTE_W), .Depth(CELLS)) u_vote_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i (vram_wdata),
    .rdata_o (vram_rdata)
  );

  // multiplier operand sequence
  always_comb begin
    px = $signed(OPND_W'(col_q)) - $signed(OPND_W'(IMG_WIDTH / 2));
    py = $signed(OPND_W'(IMG_HEIGHT / 2)) - $signed(OPND_W'(row_q));
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    unique case (state_q)
      S_MAG: begin
        // gx^2 + gy^2 - thr^2
        unique case (step_q)
          3'd0: begin mac_op = '{1'b1, 1'b1, 1'b0}; mac_a = OPND_W'(gx_q); mac_b = OPND_W'(gx_q); end
          3'd1: begin mac_op = '{1'b1, 1'b0, 1'b0}; mac_a = OPND_W'(gy_q); mac_b = OPND_W'(gy_q); end
          3'd2: begin
            mac_op = '{1'b1, 1'b0, 1'b1};
            mac_a = $signed({1'b0, thr_q}); mac_b = $signed({1'b0, thr_q});
          end
          default: mac_op = '0;
        endcase
      end
      S_RHO: begin
        unique case (step_q)
          3'd0: begin mac_op = '{1'b1, 1'b1, 1'b0}; mac_a = px; mac_b = c1_q; end
          3'd1: begin mac_op = '{1'b1, 1'b0, 1'b0}; mac_a = py; mac_b = s1_q; end
          default: mac_op = '0;
        endcase
      end
      S_PROD: begin
        // det, x numerator, y numerator
        unique case (step_q)
          3'd0: begin mac_op = '{1'b1, 1'b1, 1'b0}; mac_a = c1_q; mac_b = s2_q; end
          3'd1: begin mac_op = '{1'b1, 1'b0, 1'b1}; mac_a = s1_q; mac_b = c2_q; end
          3'd2: begin mac_op = '{1'b1, 1'b1, 1'b0}; mac_a = OPND_W'(r1_q); mac_b = s2_q; end
          3'd3: begin mac_op = '{1'b1, 1'b0, 1'b1}; mac_a = OPND_W'(r2_q); mac_b = s1_q; end
          3'd4: begin mac_op = '{1'b1, 1'b1, 1'b0}; mac_a = c1_q; mac_b = OPND_W'(r2_q); end
          3'd5: begin mac_op = '{1'b1, 1'b0, 1'b1}; mac_a = c2_q; mac_b = OPND_W'(r1_q); end
          default: mac_op = '0;
        endcase
      end
      default: mac_op = '0;
    endcase
  end

  assign cord_ang_in = (state_q == S_SC2) ? ang2_q : ang_q;

  // sequencer
  always_comb begin
    state_d = state_q; step_d = step_q;
    clr_cnt_d = clr_cnt_q; clr_reply_d = clr_reply_q;
    res_acc_d = res_acc_q; res_full_d = res_full_q;
    line_total_d = line_total_q;
    best_votes_d = best_votes_q; best_col_d = best_col_q; best_row_d = best_row_q;
    gx_d = gx_q; gy_d = gy_q; row_d = row_q; col_d = col_q;
    i1_d = i1_q; i2_d = i2_q;
    ang_d = ang_q; ang2_d = ang2_q; r1_d = r1_q; r2_d = r2_q;
    c1_d = c1_q; s1_d = s1_q; c2_d = c2_q; s2_d = s2_q;
    det_d = det_q; xn_d = xn_q; yn_d = yn_q;
    numx_d = numx_q; numy_d = numy_q; den_d = den_q;
    cx_d = cx_q; cy_d = cy_q; cell_d = cell_q;

    cord_req  = '0;
    div_start = 1'b0;
    lram_we   = 1'b0;
    lram_addr = LINE_AW'(i1_q);
    lram_wdata = '0;
    vram_we   = 1'b0;
    vram_addr = cell_q;
    vram_wdata = '0;
    vote_new  = (vram_rdata == '1) ? vram_rdata : vram_rdata + 1'b1;
    in_i.ready = (state_q == S_IDLE);

    fold_gap = $signed({1'b0, ang_q[14:0]}) - $signed({1'b0, lram_rdata[30:16]});
    if (fold_gap[15]) begin
      fold_gap = -fold_gap;
    end
    rho_sum = (mac_acc + ACC_W'(1024)) >>> 11;

    det_w = NUM_W'(det_q);
    xn_w  = NUM_W'(xn_q);
    yn_w  = NUM_W'(yn_q);
    nx = (xn_w <<< 11) + det_w * $signed(NUM_W'(IMG_WIDTH / 2));
    ny = det_w * $signed(NUM_W'(IMG_HEIGHT / 2)) - (yn_w <<< 11);

    unique case (state_q)
      S_CLEAR: begin
        // one vote cell per cycle
        vram_we   = 1'b1;
        vram_addr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CELL_AW'(CELLS - 1)) begin
          state_d = clr_reply_q ? S_FINISH : S_IDLE;
          clr_reply_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          gx_d = in_i.grad_x; gy_d = in_i.grad_y;
          row_d = in_i.pixel_row; col_d = in_i.pixel_col;
          i1_d = in_i.first_line; i2_d = in_i.second_line;
          res_acc_d = 1'b0; res_full_d = 1'b0;
          step_d = '0;
          unique case (op_e'(in_i.operation))
            OP_NEW_FRAME: begin
              line_total_d = '0;
              best_votes_d = '0; best_col_d = '0; best_row_d = '0;
              clr_cnt_d = '0;
              clr_reply_d = 1'b1;
              state_d = S_CLEAR;
            end
            OP_EDGE: begin
              if (32'(in_i.pixel_row) >= IMG_HEIGHT || 32'(in_i.pixel_col) >= IMG_WIDTH) begin
                state_d = S_FINISH;
              end else begin
                state_d = S_MAG;
              end
            end
            OP_VOTE: begin
              if (in_i.first_line == in_i.second_line ||
                  LCNT_W'(in_i.first_line) >= line_total_q ||
                  LCNT_W'(in_i.second_line) >= line_total_q) begin
                state_d = S_FINISH;
              end else begin
                state_d = S_RD1;
              end
            end
            OP_REPORT: state_d = S_FINISH;
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_MAG: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd3) begin
          // weak gradient
          state_d = mac_acc[ACC_W-1] ? S_FINISH : S_ATAN;
        end
      end
      S_ATAN: begin
        cord_req = '{1'b1, 1'b1};
        state_d = S_ATANW;
      end
      S_ATANW: begin
        if (cord_done) begin
          ang_d = cord_angle;
          priority if (in_band(cord_angle)) begin
            state_d = S_FINISH;
          end else if (line_total_q >= LCNT_W'(MAX_LINES)) begin
            res_full_d = 1'b1;
            state_d = S_FINISH;
          end else begin
            state_d = S_SCE;
          end
        end
      end
      S_SCE: begin
        cord_req = '{1'b1, 1'b0};
        state_d = S_SCEW;
      end
      S_SCEW: begin
        if (cord_done) begin
          c1_d = cord_cos; s1_d = cord_sin;
          step_d = '0;
          state_d = S_RHO;
        end
      end
      S_RHO: begin
        step_d = step_q + 1'b1;
        lram_addr = line_total_q[LINE_AW-1:0];
        if (step_q == 3'd2) begin
          lram_we = 1'b1;
          lram_wdata = {ang_q, rho_sum[RHO_W-1:0]};
          line_total_d = line_total_q + 1'b1;
          res_acc_d = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_RD1: begin
        lram_addr = LINE_AW'(i1_q);
        state_d = S_RD2;
      end
      S_RD2: begin
        lram_addr = LINE_AW'(i2_q);
        ang_d = $signed(lram_rdata[31:16]);
        r1_d  = $signed(lram_rdata[15:0]);
        state_d = S_RD3;
      end
      S_RD3: begin
        ang2_d = $signed(lram_rdata[31:16]);
        r2_d   = $signed(lram_rdata[15:0]);
        // lines too close in direction after folding
        state_d = (fold_gap <= FOLD_GAP) ? S_FINISH : S_SC1;
      end
      S_SC1: begin
        cord_req = '{1'b1, 1'b0};
        state_d = S_SC1W;
      end
      S_SC1W: begin
        if (cord_done) begin
          c1_d = cord_cos; s1_d = cord_sin;
          state_d = S_SC2;
        end
      end
      S_SC2: begin
        cord_req = '{1'b1, 1'b0};
        state_d = S_SC2W;
      end
      S_SC2W: begin
        if (cord_done) begin
          c2_d = cord_cos; s2_d = cord_sin;
          step_d = '0;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          3'd2: det_d = mac_acc;
          3'd4: xn_d = mac_acc;
          3'd6: begin
            yn_d = mac_acc;
            state_d = S_NUM;
          end
          default: step_d = step_q + 1'b1;
        endcase
      end
      S_NUM: begin
        if (det_q < PAR_LIM && det_q > -PAR_LIM) begin
          // near-parallel pair
          state_d = S_FINISH;
        end else begin
          if (det_q[ACC_W-1]) begin
            numx_d = -nx; numy_d = -ny; den_d = NUM_W'(-det_w);
          end else begin
            numx_d = nx; numy_d = ny; den_d = NUM_W'(det_w);
          end
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        div_start = 1'b1;
        state_d = S_DIVXW;
      end
      S_DIVXW: begin
        if (div_done) begin
          if (!div_ok || 32'(div_quo) >= IMG_WIDTH) begin
            state_d = S_FINISH;
          end else begin
            cx_d = div_quo;
            state_d = S_DIVY;
          end
        end
      end
      S_DIVY: begin
        div_start = 1'b1;
        state_d = S_DIVYW;
      end
      S_DIVYW: begin
        if (div_done) begin
          if (!div_ok || 32'(div_quo) >= IMG_HEIGHT) begin
            state_d = S_FINISH;
          end else begin
            cy_d = div_quo;
            cell_d = CELL_AW'(32'(div_quo) * IMG_WIDTH + 32'(cx_q));
            state_d = S_CELLRD;
          end
        end
      end
      S_CELLRD: begin
        state_d = S_CELLWR;
      end
      S_CELLWR: begin
        // saturating increment and running peak
        vram_we = 1'b1;
        vram_wdata = vote_new;
        if (vote_new > best_votes_q) begin
          best_votes_d = vote_new;
          best_col_d = COL_W'(cx_q);
          best_row_d = ROW_W'(cy_q);
        end
        res_acc_d = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (state_q == S_FINISH) ? 1'b1 : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q <= '0;
      clr_cnt_q <= '0;
      clr_reply_q <= 1'b0;
      res_acc_q <= 1'b0;
      res_full_q <= 1'b0;
      line_total_q <= '0;
      best_votes_q <= '0;
      best_col_q <= '0;
      best_row_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      clr_cnt_q <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      res_acc_q <= res_acc_d;
      res_full_q <= res_full_d;
      line_total_q <= line_total_d;
      best_votes_q <= best_votes_d;
      best_col_q <= best_col_d;
      best_row_q <= best_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx_d; gy_q <= gy_d; row_q <= row_d; col_q <= col_d;
    i1_q <= i1_d; i2_q <= i2_d;
    ang_q <= ang_d; ang2_q <= ang2_d; r1_q <= r1_d; r2_q <= r2_d;
    c1_q <= c1_d; s1_q <= s1_d; c2_q <= c2_d; s2_q <= s2_d;
    det_q <= det_d; xn_q <= xn_d; yn_q <= yn_d;
    numx_q <= numx_d; numy_q <= numy_d; den_q <= den_d;
    cx_q <= cx_d; cy_q <= cy_d; cell_q <= cell_d;
    if (state_q == S_FINISH && (!out_valid_q || out_o.ready)) begin
      o_acc_q   <= res_acc_q;
      o_full_q  <= res_full_q;
      o_lines_q <= line_total_q;
      o_col_q   <= 8'(best_col_q);
      o_row_q   <= 8'(best_row_q);
      o_votes_q <= best_votes_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = o_acc_q;
  assign out_o.table_full   = o_full_q;
  assign out_o.lines_stored = o_lines_q;
  assign out_o.peak_col     = o_col_q;
  assign out_o.peak_row     = o_row_q;
  assign out_o.peak_votes   = o_votes_q;

  // line table never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_total_q <= LCNT_W'(MAX_LINES))
    else $error("line count above table size");

  // peak only falls on a new frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && in_i.operation == OP_NEW_FRAME) |=> best_votes_q >= $past(best_votes_q))
    else $error("peak votes decreased outside new frame");

  // cordic is never restarted while iterating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_req.start |-> !cord_busy)
    else $error("cordic started while busy");

  // vote memory written only by the clear pass or a counted vote
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vram_we |-> (state_q == S_CLEAR || state_q == S_CELLWR))
    else $error("unexpected vote memory write");

endmodule

>>> tb/vanishing_point_voting_tb.sv
module vanishing_point_voting_tb;
  import vpv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // generous cycle budget: reset clear, a few frame clears, random run
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     PHASE_ITEMS = 270;

  typedef struct packed {
    logic              accepted;
    logic              table_full;
    logic [LCNT_W-1:0] lines_stored;
    logic [7:0]        peak_col;
    logic [7:0]        peak_row;
    logic [VOTE_W-1:0] peak_votes;
  } vp_result_t;

  typedef struct {
    op_e              op;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    bit               typed;
    vp_result_t       res;
  } vp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;

  vpv_in_if  in_if ();
  vpv_out_if out_if ();

  vanishing_point_voting u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the voter state
  logic [15:0] shadow_angle [MAX_LINES];
  logic [15:0] shadow_rho   [MAX_LINES];
  logic [15:0] shadow_votes [CELLS];
  int unsigned shadow_lines;
  int unsigned shadow_best_cell;
  logic [15:0] shadow_best_votes;
  logic [15:0] shadow_threshold;

  vp_result_t expected_results [$];
  int         error_count;
  longint     cycle_count;
  bit         no_idle;
  int         vp_x, vp_y;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  // cordic vectoring, 65536 steps per turn
  function automatic logic signed [15:0] cordic_angle(input int gx, input int gy);
    longint     x, y, nx;
    logic [31:0] z, t;
    if (gx == 0 && gy == 0) return '0;
    x = longint'(gx) * 16384;
    y = longint'(gy) * 16384;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARC_TABLE[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARC_TABLE[i];
      end
      x = nx;
    end
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  // cordic rotation, q15 cosine and sine
  task automatic cordic_sincos(input int ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = longint'(ang) * 65536;
    x = longint'(CORDIC_KINV);
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ARC_TABLE[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ARC_TABLE[i]);
      end
      x = nx;
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic bit near_axis(input int a);
    return (a >= -2086 && a <= 2086) || (a - 16384 >= -2086 && a - 16384 <= 2086) ||
           a >= 30682 || a <= -30682;
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  // updates the shadow state and returns the result of one operation
  task automatic predict_vote_result(input vp_item_t it, output vp_result_t res);
    longint m2, t2, c1, s1, c2, s2, r1, r2, det, xn, yn, cx, cy, px, py, rho;
    int     a1, a2, d;
    int unsigned cell_idx;
    res = '0;
    case (it.op)
      OP_NEW_FRAME: begin
        foreach (shadow_votes[k]) shadow_votes[k] = '0;
        shadow_lines = 0;
        shadow_best_cell = 0;
        shadow_best_votes = '0;
      end
      OP_EDGE: begin
        m2 = longint'(it.gx) * it.gx + longint'(it.gy) * it.gy;
        t2 = longint'(shadow_threshold) * shadow_threshold;
        a1 = cordic_angle(it.gx, it.gy);
        if (m2 >= t2 && !near_axis(a1)) begin
          if (shadow_lines >= MAX_LINES) begin
            res.table_full = 1'b1;
          end else begin
            cordic_sincos(a1, c1, s1);
            px = longint'(it.col) - IMG_WIDTH / 2;
            py = IMG_HEIGHT / 2 - longint'(it.row);
            rho = (px * c1 + py * s1 + 1024) >>> 11;
            shadow_angle[shadow_lines] = a1[15:0];
            shadow_rho[shadow_lines] = rho[15:0];
            shadow_lines++;
            res.accepted = 1'b1;
          end
        end
      end
      OP_VOTE: begin
        if (it.i1 != it.i2 && it.i1 < shadow_lines && it.i2 < shadow_lines) begin
          a1 = $signed(shadow_angle[it.i1]);
          a2 = $signed(shadow_angle[it.i2]);
          d = (a1 < 0 ? a1 + 32768 : a1) - (a2 < 0 ? a2 + 32768 : a2);
          if (d < 0) d = -d;
          if (d > 3650) begin
            cordic_sincos(a1, c1, s1);
            cordic_sincos(a2, c2, s2);
            r1 = $signed(shadow_rho[it.i1]);
            r2 = $signed(shadow_rho[it.i2]);
            det = c1 * s2 - s1 * c2;
            if (det >= 11 || det <= -11) begin
              xn = r1 * s2 - r2 * s1;
              yn = c1 * r2 - c2 * r1;
              cx = floor_quot(xn * 2048 + (IMG_WIDTH / 2) * det, det);
              cy = floor_quot((IMG_HEIGHT / 2) * det - yn * 2048, det);
              if (cx >= 0 && cx < IMG_WIDTH && cy >= 0 && cy < IMG_HEIGHT) begin
                cell_idx = int'(cy) * IMG_WIDTH + int'(cx);
                if (shadow_votes[cell_idx] != 16'hFFFF) shadow_votes[cell_idx]++;
                if (shadow_votes[cell_idx] > shadow_best_votes) begin
                  shadow_best_votes = shadow_votes[cell_idx];
                  shadow_best_cell = cell_idx;
                end
                res.accepted = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.lines_stored = shadow_lines[LCNT_W-1:0];
    res.peak_col = 8'(shadow_best_cell % IMG_WIDTH);
    res.peak_row = 8'(shadow_best_cell / IMG_WIDTH);
    res.peak_votes = shadow_best_votes;
  endtask

  // one input transfer with a random gap in front
  task automatic send_item(input vp_item_t it);
    int         gap;
    vp_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= it.op;
    in_if.grad_x      <= it.gx;
    in_if.grad_y      <= it.gy;
    in_if.pixel_row   <= it.row;
    in_if.pixel_col   <= it.col;
    in_if.first_line  <= it.i1;
    in_if.second_line <= it.i2;
    do @(posedge clk_i); while (!in_if.ready);
    predict_vote_result(it, res);
    expected_results.push_back(it.typed ? it.res : res);
    if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
  endtask

  function automatic vp_item_t make_item(input op_e op, input int gx, input int gy,
                                         input int row, input int col,
                                         input int i1, input int i2);
    vp_item_t it;
    it.op = op;
    it.gx = 16'(gx);
    it.gy = 16'(gy);
    it.row = 8'(row);
    it.col = 8'(col);
    it.i1 = IDX_W'(i1);
    it.i2 = IDX_W'(i2);
    it.typed = 1'b0;
    it.res = '0;
    return it;
  endfunction

  // rows with a hand-written result: everything still zero
  function automatic vp_item_t zero_row(input op_e op, input int gx, input int gy);
    vp_item_t it;
    it = make_item(op, gx, gy, 10, 20, 0, 0);
    it.typed = 1'b1;
    return it;
  endfunction

  // edge pixel on a line through the current vanishing point
  function automatic vp_item_t aligned_edge();
    real th, t, mag;
    int  col, row;
    th = $urandom_range(0, 62831) / 10000.0;
    mag = $urandom_range(50, 20000);
    for (int k = 0; k < 8; k++) begin
      t = $itor($urandom_range(0, 300)) - 150.0;
      col = $rtoi(vp_x - t * $sin(th) + 128.5);
      row = $rtoi(128.5 - (vp_y + t * $cos(th)));
      if (col >= 0 && col < IMG_WIDTH && row >= 0 && row < IMG_HEIGHT)
        return make_item(OP_EDGE, $rtoi(mag * $cos(th)), $rtoi(mag * $sin(th)), row, col, 0, 0);
    end
    return make_item(OP_EDGE, $urandom(), $urandom(), $urandom(), $urandom(), 0, 0);
  endfunction

  function automatic vp_item_t random_item();
    int pick, hi;
    pick = $urandom_range(0, 99);
    hi = shadow_lines > 0 ? shadow_lines - 1 : 0;
    if (pick < 55) return aligned_edge();
    if (pick < 65) return make_item(OP_EDGE, $urandom(), $urandom(), $urandom(), $urandom(), 0, 0);
    if (pick < 88) return make_item(OP_VOTE, 0, 0, 0, 0, $urandom_range(0, hi), $urandom_range(0, hi));
    if (pick < 92) return make_item(OP_VOTE, 0, 0, 0, 0, $urandom(), $urandom());
    if (pick < 94) return make_item(OP_VOTE, 0, 0, 0, 0, hi, hi);
    return make_item(OP_REPORT, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  // apb write with readback, only while the block is idle
  task automatic write_threshold(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_THRESHOLD * 4);
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_threshold = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== value) report_mismatch("prdata", prdata[15:0], value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // receiver: random stall per result, compare with the oldest expectation
  initial begin
    vp_result_t got, want;
    int         gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = '{out_if.accepted, out_if.table_full, out_if.lines_stored,
              out_if.peak_col, out_if.peak_row, out_if.peak_votes};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", got.table_full, want.table_full);
        if (got.lines_stored !== want.lines_stored)
          report_mismatch("lines_stored", got.lines_stored, want.lines_stored);
        if (got.peak_col !== want.peak_col) report_mismatch("peak_col", got.peak_col, want.peak_col);
        if (got.peak_row !== want.peak_row) report_mismatch("peak_row", got.peak_row, want.peak_row);
        if (got.peak_votes !== want.peak_votes)
          report_mismatch("peak_votes", got.peak_votes, want.peak_votes);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    vp_item_t    directed [$];
    logic [15:0] thr_steps [5];
    error_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    shadow_lines = 0;
    shadow_best_cell = 0;
    shadow_best_votes = '0;
    shadow_threshold = THR_RESET;
    foreach (shadow_votes[k]) shadow_votes[k] = '0;
    foreach (shadow_angle[k]) begin
      shadow_angle[k] = '0;
      shadow_rho[k] = '0;
    end
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_REPORT;
    in_if.grad_x <= '0;
    in_if.grad_y <= '0;
    in_if.pixel_row <= '0;
    in_if.pixel_col <= '0;
    in_if.first_line <= '0;
    in_if.second_line <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; typed rows are read off directly, the rest go to the predictor
    directed.push_back(zero_row(OP_REPORT, 0, 0));
    directed.push_back(zero_row(OP_EDGE, 0, 0));          // zero gradient
    directed.push_back(zero_row(OP_EDGE, 20, 20));        // just under threshold
    directed.push_back(zero_row(OP_EDGE, 32767, 0));      // band around 0
    directed.push_back(zero_row(OP_EDGE, 0, 32767));      // band around +pi/2
    directed.push_back(zero_row(OP_EDGE, -32768, 0));     // band around pi
    directed.push_back(zero_row(OP_EDGE, -32768, 5));     // band around +pi
    directed.push_back(make_item(OP_EDGE, 0, -32768, 0, 0, 0, 0));  // -pi/2 is kept
    directed.push_back(make_item(OP_EDGE, -32768, -32768, 255, 255, 0, 0));
    directed.push_back(make_item(OP_EDGE, 1000, 500, 0, 255, 0, 0));
    directed.push_back(make_item(OP_EDGE, -700, 900, 128, 128, 0, 0));
    directed.push_back(make_item(OP_EDGE, 32767, -32768, 255, 0, 0, 0));
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 0, 0));       // equal indices
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 1, 2));
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 2, 3));
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 3, 4));
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 1, 3));
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 4095, 0));    // index past the table
    directed.push_back(make_item(OP_VOTE, 0, 0, 0, 0, 0, 4095));
    directed.push_back(make_item(OP_REPORT, -1, -1, 255, 255, 4095, 4095));
    directed.push_back(zero_row(OP_NEW_FRAME, 0, 0));
    directed.push_back(zero_row(OP_REPORT, 0, 0));
    foreach (directed[k]) send_item(directed[k]);
    in_if.valid <= 1'b0;
    drain();

    // random phases, each with its own threshold and vanishing point
    thr_steps = '{16'd0, 16'd65535, 16'($urandom_range(1, 400)), 16'd200, THR_RESET};
    foreach (thr_steps[p]) begin
      write_threshold(thr_steps[p]);
      vp_x = $urandom_range(0, 200) - 100;
      vp_y = $urandom_range(0, 200) - 100;
      send_item(make_item(OP_NEW_FRAME, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom()));
      repeat (PHASE_ITEMS) send_item(random_item());
      in_if.valid <= 1'b0;
      drain();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/vpv_pkg.sv
src/vpv_if.sv
src/vpv_ram.sv
src/vpv_cordic.sv
src/vpv_mac.sv
src/vpv_div.sv
src/vanishing_point_voting.sv
tb/vanishing_point_voting_tb.sv
